FILE: rtl/core/ffha_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants, segment record and control types for the first-fit
// heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 32768;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_SEGMENTS = 2048;

    localparam int ADDR_W = 15;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = IDX_W + 1;

    localparam logic [ADDR_W-1:0] HDR       = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SEGMENTS);

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_seg;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [CNT_W-1:0] shift_lim;
        logic [CNT_W-1:0] wpos;
        t_seg             data;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_EXACT   = 3'd0,
        ST_SPLIT   = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_FREED   = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_FLUSH,
        S_REPORT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/ffha_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffha_cell
// One entry of the segment row. It takes its right neighbor's entry when the
// row shifts toward the head, or the pushed entry when it is the tail slot.
// ---------------------------------------------------------------------------
module ffha_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ffha_pkg::IDX_W-1:0]  i_index,
    input  wire ffha_pkg::t_seg              i_rst_seg,
    input  wire ffha_pkg::t_cell_ctl         i_ctl,
    input  wire ffha_pkg::t_seg              i_next,
    output ffha_pkg::t_seg                   o_seg
);
    import ffha_pkg::*;

    t_seg             r_seg;
    logic [CNT_W-1:0] pos;

    assign pos = {1'b0, i_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= i_rst_seg;
        end else if (i_ctl.pop && (pos < i_ctl.shift_lim)) begin
            r_seg <= i_next;
        end else if (i_ctl.push && (pos == i_ctl.wpos)) begin
            r_seg <= i_ctl.data;
        end
    end

    assign o_seg = r_seg;

endmodule
`default_nettype wire

FILE: rtl/core/ffha_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer. Rotates the segment row once per request through a
// one-entry hold register, deciding on each entry as it leaves the head.
// ---------------------------------------------------------------------------
module ffha_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic                        i_operation,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_request_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_free_address,
    input  wire ffha_pkg::t_seg              i_head,
    output ffha_pkg::t_cell_ctl              o_ctl,
    output logic                             busy,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [ffha_pkg::ADDR_W-1:0]      o_data_address
);
    import ffha_pkg::*;

    t_state            r_state, n_state;
    logic              r_op;
    logic [ADDR_W-1:0] r_req, r_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_pcnt, n_pcnt;
    logic              r_full;
    t_seg              r_hold, n_hold;
    logic              r_hv, n_hv;
    t_seg              r_rest, n_rest;
    logic              r_found, n_found;
    logic              r_merge, n_merge;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_daddr, n_daddr;

    logic              pop, push;
    logic              split;
    t_seg              e2;
    logic              absorb;
    logic [ADDR_W:0]   req_hdr;
    logic [ADDR_W:0]   e_start;

    assign req_hdr = {1'b0, r_req} + {1'b0, HDR};
    assign e_start = {1'b0, i_head.offset} + {1'b0, HDR};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_SCAN;
            S_SCAN:   begin
                if (split) n_state = S_SPLIT;
                else if (r_left == CNT_W'(1)) n_state = S_FLUSH;
            end
            S_SPLIT:  n_state = (r_left == '0) ? S_FLUSH : S_SCAN;
            S_FLUSH:  n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Row control and entry decisions.
    always_comb begin
        pop      = 1'b0;
        push     = 1'b0;
        split    = 1'b0;
        absorb   = 1'b0;
        e2       = i_head;
        n_hold   = r_hold;
        n_hv     = r_hv;
        n_rest   = r_rest;
        n_found  = r_found;
        n_merge  = 1'b0;
        n_status = r_status;
        n_daddr  = r_daddr;
        n_left   = r_left;
        o_ctl.data = r_hold;
        case (r_state)
            S_SCAN: begin
                pop    = 1'b1;
                n_left = r_left - CNT_W'(1);
                if (!r_found && !r_op) begin
                    if (i_head.free && (i_head.size >= r_req)) begin
                        n_found = 1'b1;
                        n_daddr = e_start[ADDR_W-1:0];
                        if (i_head.size == r_req) begin
                            e2.free  = 1'b0;
                            n_status = ST_EXACT;
                        end else if (({1'b0, i_head.size} > req_hdr) && !r_full) begin
                            split       = 1'b1;
                            e2.size     = r_req;
                            e2.free     = 1'b0;
                            n_status    = ST_SPLIT;
                            n_rest.offset = ADDR_W'(e_start + {1'b0, r_req});
                            n_rest.size   = i_head.size - r_req - HDR;
                            n_rest.free   = 1'b1;
                        end else begin
                            n_status = ST_NOMEM;
                        end
                    end
                end else if (!r_found && r_op && (e_start == {1'b0, r_addr})) begin
                    n_found = 1'b1;
                    if (i_head.free) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_status = ST_FREED;
                        n_merge  = 1'b1;
                        e2.free  = 1'b1;
                        if (r_hv && r_hold.free) absorb = 1'b1;
                    end
                end else if (r_merge && i_head.free) begin
                    absorb = 1'b1;
                end
                if (absorb) begin
                    n_hold.size = r_hold.size + i_head.size + HDR;
                    n_hold.free = 1'b1;
                end else begin
                    push   = r_hv;
                    n_hold = e2;
                    n_hv   = 1'b1;
                end
            end
            S_SPLIT: begin
                push   = 1'b1;
                n_hold = r_rest;
            end
            S_FLUSH: begin
                push = 1'b1;
                n_hv = 1'b0;
            end
            default: ;
        endcase
        o_ctl.pop       = pop;
        o_ctl.push      = push;
        o_ctl.shift_lim = r_pcnt - CNT_W'(1);
        o_ctl.wpos      = pop ? (r_pcnt - CNT_W'(1)) : r_pcnt;
        n_pcnt = r_pcnt;
        if (push && !pop) n_pcnt = r_pcnt + CNT_W'(1);
        else if (pop && !push) n_pcnt = r_pcnt - CNT_W'(1);
    end

    // Outputs.
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_valid        = (r_state == S_REPORT);
        o_status       = r_found ? r_status : (r_op ? ST_INVALID : ST_NOMEM);
        o_data_address = (r_found && (r_status == ST_EXACT || r_status == ST_SPLIT))
                         ? r_daddr : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pcnt  <= CNT_W'(1);
            r_hv    <= 1'b0;
            r_found <= 1'b0;
            r_merge <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            if (r_state == S_IDLE) begin
                r_hv    <= 1'b0;
                r_found <= 1'b0;
                r_merge <= 1'b0;
                r_left  <= r_pcnt;
            end else begin
                r_hv    <= n_hv;
                r_found <= n_found;
                r_merge <= n_merge;
                r_left  <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op   <= i_operation;
            r_req  <= i_request_size;
            r_addr <= i_free_address;
            r_full <= (r_pcnt == MAX_CNT);
        end
        r_hold   <= n_hold;
        r_rest   <= n_rest;
        r_status <= n_status;
        r_daddr  <= n_daddr;
    end

    // The row may be empty mid-request while its only entry sits in the hold
    // register, but never between requests.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt <= MAX_CNT) && ((r_state != S_IDLE) || (r_pcnt != '0)))
        else $error("segment count out of range");
    a_pop_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_left != '0))
        else $error("pop with no entries left to visit");
    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_state == S_SCAN) |-> r_hv)
        else $error("push of an empty hold register");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> !r_hv)
        else $error("hold register not drained at end of request");

endmodule
`default_nettype wire

FILE: rtl/core/first_fit_heap_allocator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with split and coalesce over a row of segment
// cells.
// ---------------------------------------------------------------------------
// A request is transferred at a clock edge with start high and busy low:
// operation 0 allocates request_size bytes, operation 1 frees the segment
// whose data starts at free_address. Exactly one result is shown for one
// cycle with o_valid high, carrying o_status and o_data_address.
// The segment table lives in a row of cells. Each request rotates the whole
// row once through the head cell, one segment per cycle except while the
// rest of a split segment is pushed back. busy stays high until the result
// cycle ends.
// Reset (synchronous, active low) leaves one free segment covering the heap
// and takes effect at once; no clearing pass is needed.
// The receiver cannot stall; the result is gone after its single cycle.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_operation,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_request_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_free_address,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [ffha_pkg::ADDR_W-1:0]      o_data_address
);
    import ffha_pkg::*;

    t_cell_ctl ctl;
    t_seg      segs [MAX_SEGMENTS];
    t_seg      init0, init_rest, zero_seg;

    assign init0     = '{offset: '0, size: INIT_SIZE, free: 1'b1};
    assign init_rest = '0;
    assign zero_seg  = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
            ffha_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_index   (IDX_W'(k)),
                .i_rst_seg ((k == 0) ? init0 : init_rest),
                .i_ctl     (ctl),
                .i_next    ((k == MAX_SEGMENTS - 1) ? zero_seg : segs[(k + 1) % MAX_SEGMENTS]),
                .o_seg     (segs[k])
            );
        end
    endgenerate

    ffha_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_head         (segs[0]),
        .o_ctl          (ctl),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_data_address (o_data_address)
    );

endmodule
`default_nettype wire
